// ----- design/backslash_unescape_decoder_top_macros.svh -----
// Assertion helpers used by the top-level file that checks this block.
`ifndef BACKSLASH_UNESCAPE_DECODER_TOP_MACROS_SVH
`define BACKSLASH_UNESCAPE_DECODER_TOP_MACROS_SVH

// Condition a implies condition b in the same cycle.
`define BUD_ASSERT_IMPLY(label, clk, rstn, a, b) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (a) |-> (b)) \
        else $error("assertion failed: same-cycle implication");

// Condition a implies condition b in the following cycle.
`define BUD_ASSERT_NEXT(label, clk, rstn, a, b) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (a) |=> (b)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ----- design/bud_pkg.sv -----
package bud_pkg;

    localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
    localparam logic [7:0] CHAR_T         = 8'h74;
    localparam logic [7:0] CHAR_N         = 8'h6E;
    localparam logic [7:0] CHAR_R         = 8'h72;
    localparam logic [7:0] CHAR_X         = 8'h78;
    localparam logic [7:0] CODE_TAB       = 8'h09;
    localparam logic [7:0] CODE_LF        = 8'h0A;
    localparam logic [7:0] CODE_CR        = 8'h0D;
    localparam logic [4:0] HEX_INVALID    = 5'd16;

    // One input byte can release up to four output bytes.
    localparam int BURST_MAX = 4;

    typedef struct packed {
        logic [BURST_MAX-1:0][7:0] data;
        logic [2:0]                count;
        logic                      last;
    } burst_t;

    // Digit value in 0..15, or HEX_INVALID when the byte is not a hex digit.
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] v;
        v = HEX_INVALID;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            v = {1'b0, 4'(c - 8'h30)};
        end
        else if (c >= 8'h61 && c <= 8'h66)
        begin
            v = {1'b0, 4'(c - 8'h57)};
        end
        else if (c >= 8'h41 && c <= 8'h46)
        begin
            v = {1'b0, 4'(c - 8'h37)};
        end
        return v;
    endfunction

endpackage

// ----- design/bud_front.sv -----
module bud_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  logic [7:0]      in_byte,
    input  logic            in_last,
    output logic            in_ready,
    input  logic            queue_full,
    output logic            push_valid,
    output bud_pkg::burst_t push_burst
);

    typedef enum logic [3:0] {
        PH_IDLE  = 4'b0001,
        PH_SLASH = 4'b0010,
        PH_X     = 4'b0100,
        PH_DIGIT = 4'b1000
    } phase_t;

    phase_t     phase_reg, phase_next;
    logic [7:0] held_reg, held_next;

    logic                                   accept;
    logic [bud_pkg::BURST_MAX-1:0][7:0]     bytes_v;
    logic [2:0]                             cnt_v;
    logic [4:0]                             in_hex;
    logic [4:0]                             held_hex;

    assign in_ready = !queue_full;
    assign accept   = in_valid && in_ready;
    assign in_hex   = bud_pkg::hex_value(in_byte);
    assign held_hex = bud_pkg::hex_value(held_reg);

    always_comb
    begin
        bytes_v    = '0;
        cnt_v      = 3'd0;
        phase_next = phase_reg;
        held_next  = held_reg;
        case (phase_reg)
            PH_IDLE:
            begin
                if (in_byte == bud_pkg::CHAR_BACKSLASH)
                begin
                    phase_next = PH_SLASH;
                end
                else
                begin
                    bytes_v[cnt_v[1:0]] = in_byte;
                    cnt_v = cnt_v + 3'd1;
                end
            end
            PH_SLASH:
            begin
                phase_next = PH_IDLE;
                if (in_byte == bud_pkg::CHAR_BACKSLASH)
                begin
                    bytes_v[cnt_v[1:0]] = bud_pkg::CHAR_BACKSLASH;
                    cnt_v = cnt_v + 3'd1;
                end
                else if (in_byte == bud_pkg::CHAR_T)
                begin
                    bytes_v[cnt_v[1:0]] = bud_pkg::CODE_TAB;
                    cnt_v = cnt_v + 3'd1;
                end
                else if (in_byte == bud_pkg::CHAR_N)
                begin
                    bytes_v[cnt_v[1:0]] = bud_pkg::CODE_LF;
                    cnt_v = cnt_v + 3'd1;
                end
                else if (in_byte == bud_pkg::CHAR_R)
                begin
                    bytes_v[cnt_v[1:0]] = bud_pkg::CODE_CR;
                    cnt_v = cnt_v + 3'd1;
                end
                else if (in_byte == bud_pkg::CHAR_X)
                begin
                    phase_next = PH_X;
                end
                else
                begin
                    // Unknown escape: the backslash goes out literally and the
                    // byte is taken afresh (it cannot be a backslash here).
                    bytes_v[cnt_v[1:0]] = bud_pkg::CHAR_BACKSLASH;
                    cnt_v = cnt_v + 3'd1;
                    bytes_v[cnt_v[1:0]] = in_byte;
                    cnt_v = cnt_v + 3'd1;
                end
            end
            PH_X:
            begin
                if (in_hex != bud_pkg::HEX_INVALID)
                begin
                    held_next  = in_byte;
                    phase_next = PH_DIGIT;
                end
                else
                begin
                    phase_next = PH_IDLE;
                    bytes_v[cnt_v[1:0]] = bud_pkg::CHAR_BACKSLASH;
                    cnt_v = cnt_v + 3'd1;
                    bytes_v[cnt_v[1:0]] = bud_pkg::CHAR_X;
                    cnt_v = cnt_v + 3'd1;
                    if (in_byte == bud_pkg::CHAR_BACKSLASH)
                    begin
                        phase_next = PH_SLASH;
                    end
                    else
                    begin
                        bytes_v[cnt_v[1:0]] = in_byte;
                        cnt_v = cnt_v + 3'd1;
                    end
                end
            end
            PH_DIGIT:
            begin
                phase_next = PH_IDLE;
                if (in_hex != bud_pkg::HEX_INVALID)
                begin
                    bytes_v[cnt_v[1:0]] = {held_hex[3:0], in_hex[3:0]};
                    cnt_v = cnt_v + 3'd1;
                end
                else
                begin
                    bytes_v[cnt_v[1:0]] = bud_pkg::CHAR_BACKSLASH;
                    cnt_v = cnt_v + 3'd1;
                    bytes_v[cnt_v[1:0]] = bud_pkg::CHAR_X;
                    cnt_v = cnt_v + 3'd1;
                    bytes_v[cnt_v[1:0]] = held_reg;
                    cnt_v = cnt_v + 3'd1;
                    if (in_byte == bud_pkg::CHAR_BACKSLASH)
                    begin
                        phase_next = PH_SLASH;
                    end
                    else
                    begin
                        bytes_v[cnt_v[1:0]] = in_byte;
                        cnt_v = cnt_v + 3'd1;
                    end
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase

        // At the end of the text a pending escape is flushed as it stands.
        if (in_last)
        begin
            if (phase_next != PH_IDLE)
            begin
                bytes_v[cnt_v[1:0]] = bud_pkg::CHAR_BACKSLASH;
                cnt_v = cnt_v + 3'd1;
            end
            if (phase_next == PH_X || phase_next == PH_DIGIT)
            begin
                bytes_v[cnt_v[1:0]] = bud_pkg::CHAR_X;
                cnt_v = cnt_v + 3'd1;
            end
            if (phase_next == PH_DIGIT)
            begin
                bytes_v[cnt_v[1:0]] = held_next;
                cnt_v = cnt_v + 3'd1;
            end
            phase_next = PH_IDLE;
            held_next  = 8'h00;
        end
    end

    assign push_valid       = accept && (cnt_v != 3'd0);
    assign push_burst.data  = bytes_v;
    assign push_burst.count = cnt_v;
    assign push_burst.last  = in_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            held_reg  <= 8'h00;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            held_reg  <= held_next;
        end
    end

endmodule

// ----- design/bud_queue.sv -----
module bud_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr_valid,
    input  bud_pkg::burst_t wr_burst,
    output logic            full,
    output logic            rd_valid,
    output bud_pkg::burst_t rd_burst,
    input  logic            rd_ready
);

    bud_pkg::burst_t entry_reg [2];
    logic            wr_ptr_reg, wr_ptr_next;
    logic            rd_ptr_reg, rd_ptr_next;
    logic [1:0]      fill_reg, fill_next;
    logic            do_wr, do_rd;

    assign full     = (fill_reg == 2'd2);
    assign rd_valid = (fill_reg != 2'd0);
    assign rd_burst = entry_reg[rd_ptr_reg];
    assign do_wr    = wr_valid && !full;
    assign do_rd    = rd_ready && rd_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ do_wr;
        rd_ptr_next = rd_ptr_reg ^ do_rd;
        fill_next   = fill_reg;
        if (do_wr && !do_rd)
        begin
            fill_next = fill_reg + 2'd1;
        end
        else if (do_rd && !do_wr)
        begin
            fill_next = fill_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entry_reg[wr_ptr_reg] <= wr_burst;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

endmodule

// ----- design/bud_back.sv -----
module bud_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_valid,
    input  bud_pkg::burst_t q_burst,
    output logic            q_pop,
    output logic            out_valid,
    output logic [7:0]      out_byte,
    output logic            out_run_last,
    output logic            out_text_end,
    input  logic            out_ready
);

    bud_pkg::burst_t cur_reg;
    logic            busy_reg, busy_next;
    logic [1:0]      idx_reg, idx_next;
    logic            load;

    assign out_valid    = busy_reg;
    assign out_byte     = cur_reg.data[idx_reg];
    assign out_run_last = ({1'b0, idx_reg} == (cur_reg.count - 3'd1));
    assign out_text_end = out_run_last && cur_reg.last;

    // A new request is taken when idle or as soon as the current one hands over its last byte.
    assign load  = !busy_reg || (out_ready && out_run_last);
    assign q_pop = load && q_valid;

    always_comb
    begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        if (load)
        begin
            busy_next = q_valid;
            idx_next  = 2'd0;
        end
        else if (out_ready)
        begin
            idx_next = idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cur_reg <= q_burst;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= 2'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
        end
    end

endmodule

// ----- design/backslash_unescape_decoder_top.sv -----
// Channel   Dir  tdata              tlast      tuser
// s_axis    in   [7:0] in_byte      text_last  -
// m_axis    out  [7:0] out_byte     run_last   [0] text_end
//
// The front end takes one byte per cycle while its two-entry request queue has room.
// The back end sends one decoded byte per cycle while the receiver is ready; each
// byte is held in a queue entry and then in the output register before it appears.
// rst_n clears the escape state, the queue and the output stage at once.
// Output stalls back up through the queue; the front stalls only when the queue is full.
`include "backslash_unescape_decoder_top_macros.svh"

module backslash_unescape_decoder_top (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
    input  logic       s_axis_tlast,   // text_last
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_byte
    output logic       m_axis_tlast,   // run_last
    output logic [0:0] m_axis_tuser    // [0] text_end
);

    logic            push_valid;
    bud_pkg::burst_t push_burst;
    logic            queue_full;
    logic            q_valid;
    bud_pkg::burst_t q_burst;
    logic            q_pop;
    logic            text_end;
    logic            in_accept;
    logic            out_done;

    bud_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_byte    (s_axis_tdata),
        .in_last    (s_axis_tlast),
        .in_ready   (s_axis_tready),
        .queue_full (queue_full),
        .push_valid (push_valid),
        .push_burst (push_burst)
    );

    bud_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (push_valid),
        .wr_burst (push_burst),
        .full     (queue_full),
        .rd_valid (q_valid),
        .rd_burst (q_burst),
        .rd_ready (q_pop)
    );

    bud_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_burst      (q_burst),
        .q_pop        (q_pop),
        .out_valid    (m_axis_tvalid),
        .out_byte     (m_axis_tdata),
        .out_run_last (m_axis_tlast),
        .out_text_end (text_end),
        .out_ready    (m_axis_tready)
    );

    assign m_axis_tuser = text_end;

    assign in_accept = s_axis_tvalid && s_axis_tready;
    assign out_done  = m_axis_tvalid && m_axis_tready && m_axis_tlast;

    // The final byte of a text always releases at least one output byte.
    `BUD_ASSERT_IMPLY(a_last_pushes, clk, rst_n, in_accept && s_axis_tlast, push_valid)

    // The back end takes a request only when idle or finishing the current one.
    `BUD_ASSERT_IMPLY(a_pop_at_boundary, clk, rst_n, q_pop, !m_axis_tvalid || out_done)

    // A request taken from the queue is always presented in the next cycle.
    `BUD_ASSERT_NEXT(a_pop_shows, clk, rst_n, q_pop, m_axis_tvalid)

    // The end of a text is always the last byte of its request.
    `BUD_ASSERT_IMPLY(a_end_is_run_last, clk, rst_n, m_axis_tvalid && m_axis_tuser[0], m_axis_tlast)

endmodule

// ----- tb/bud_decode_monitor.sv -----
module bud_decode_monitor (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    input  logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
    input  logic       s_axis_tlast,   // text_last
    input  logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    input  logic [7:0] m_axis_tdata,   // [7:0] out_byte
    input  logic       m_axis_tlast,   // run_last
    input  logic [0:0] m_axis_tuser,   // [0] text_end
    output int         mismatch_count,
    output int         bytes_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [3:0] {
        ESC_NONE      = 4'b0001,
        ESC_SLASH     = 4'b0010,
        ESC_HEX_X     = 4'b0100,
        ESC_HEX_DIGIT = 4'b1000
    } esc_phase_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       text_end;
    } decoded_t;

    decoded_t   decoded_q[$];
    logic [7:0] burst_q[$];
    esc_phase_t esc_phase;
    logic [7:0] held_digit;
    int         errors;

    // Returns 16 for a byte that is not a hex digit.
    function automatic logic [4:0] digit_value(input logic [7:0] c);
        if (c >= "0" && c <= "9")
        begin
            return 5'(c - "0");
        end
        if (c >= "a" && c <= "f")
        begin
            return 5'(c - "a" + 10);
        end
        if (c >= "A" && c <= "F")
        begin
            return 5'(c - "A" + 10);
        end
        return 5'd16;
    endfunction

    // A byte seen with no escape pending either opens one or passes through.
    function automatic void open_or_pass(input logic [7:0] b);
        if (b == bud_pkg::CHAR_BACKSLASH)
        begin
            esc_phase = ESC_SLASH;
        end
        else
        begin
            burst_q.push_back(b);
        end
    endfunction

    function automatic void predict_decode(input logic [7:0] b, input logic last);
        logic [4:0] lo;
        logic [4:0] hi;
        lo = digit_value(b);
        hi = digit_value(held_digit);
        burst_q.delete();
        case (esc_phase)
            ESC_NONE:
            begin
                open_or_pass(b);
            end
            ESC_SLASH:
            begin
                esc_phase = ESC_NONE;
                if (b == bud_pkg::CHAR_BACKSLASH)
                begin
                    burst_q.push_back(bud_pkg::CHAR_BACKSLASH);
                end
                else if (b == bud_pkg::CHAR_T)
                begin
                    burst_q.push_back(bud_pkg::CODE_TAB);
                end
                else if (b == bud_pkg::CHAR_N)
                begin
                    burst_q.push_back(bud_pkg::CODE_LF);
                end
                else if (b == bud_pkg::CHAR_R)
                begin
                    burst_q.push_back(bud_pkg::CODE_CR);
                end
                else if (b == bud_pkg::CHAR_X)
                begin
                    esc_phase = ESC_HEX_X;
                end
                else
                begin
                    burst_q.push_back(bud_pkg::CHAR_BACKSLASH);
                    open_or_pass(b);
                end
            end
            ESC_HEX_X:
            begin
                if (lo[4] == 1'b0)
                begin
                    held_digit = b;
                    esc_phase = ESC_HEX_DIGIT;
                end
                else
                begin
                    esc_phase = ESC_NONE;
                    burst_q.push_back(bud_pkg::CHAR_BACKSLASH);
                    burst_q.push_back(bud_pkg::CHAR_X);
                    open_or_pass(b);
                end
            end
            default:
            begin
                esc_phase = ESC_NONE;
                if (lo[4] == 1'b0)
                begin
                    burst_q.push_back({hi[3:0], lo[3:0]});
                end
                else
                begin
                    burst_q.push_back(bud_pkg::CHAR_BACKSLASH);
                    burst_q.push_back(bud_pkg::CHAR_X);
                    burst_q.push_back(held_digit);
                    open_or_pass(b);
                end
            end
        endcase

        // The final byte of a text flushes whatever escape is still open.
        if (last)
        begin
            if (esc_phase != ESC_NONE)
            begin
                burst_q.push_back(bud_pkg::CHAR_BACKSLASH);
            end
            if (esc_phase == ESC_HEX_X || esc_phase == ESC_HEX_DIGIT)
            begin
                burst_q.push_back(bud_pkg::CHAR_X);
            end
            if (esc_phase == ESC_HEX_DIGIT)
            begin
                burst_q.push_back(held_digit);
            end
            esc_phase = ESC_NONE;
            held_digit = 8'h00;
        end

        foreach (burst_q[k])
        begin
            decoded_q.push_back('{out_byte: burst_q[k],
                                  run_last: (k == burst_q.size() - 1),
                                  text_end: (k == burst_q.size() - 1) && last});
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        decoded_t want;
        if (!rst_n)
        begin
            esc_phase = ESC_NONE;
            held_digit = 8'h00;
            decoded_q.delete();
            errors = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (decoded_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected output byte %02h last=%b end=%b", $time,
                             m_axis_tdata, m_axis_tlast, m_axis_tuser[0]);
                end
                else
                begin
                    want = decoded_q.pop_front();
                    if (want.out_byte !== m_axis_tdata || want.run_last !== m_axis_tlast ||
                        want.text_end !== m_axis_tuser[0])
                    begin
                        errors++;
                        $display("%0t: expected %02h/%b/%b, got %02h/%b/%b",
                                 $time, want.out_byte, want.run_last, want.text_end,
                                 m_axis_tdata, m_axis_tlast, m_axis_tuser[0]);
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                predict_decode(s_axis_tdata, s_axis_tlast);
            end
        end
        mismatch_count <= errors;
        bytes_outstanding <= decoded_q.size();
    end

endmodule

// ----- tb/tb_backslash_unescape_decoder_top.sv -----
module tb_backslash_unescape_decoder_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEMS_PER_PHASE = 35;
    localparam int HOLD_OFF_CYCLES = 80;
    localparam int WATCHDOG_LIMIT  = 1000;
    localparam int DRAIN_CYCLES    = 20;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata = 8'h00;   // [7:0] in_byte
    logic       s_axis_tlast = 1'b0;    // text_last
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;           // [7:0] out_byte
    logic       m_axis_tlast;           // run_last
    logic [0:0] m_axis_tuser;           // [0] text_end

    int mismatch_count;
    int bytes_outstanding;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    bit hold_off_request = 1'b0;

    backslash_unescape_decoder_top u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    bud_decode_monitor u_monitor (
        .clk               (clk),
        .rst_n             (rst_n),
        .s_axis_tvalid     (s_axis_tvalid),
        .s_axis_tready     (s_axis_tready),
        .s_axis_tdata      (s_axis_tdata),
        .s_axis_tlast      (s_axis_tlast),
        .m_axis_tvalid     (m_axis_tvalid),
        .m_axis_tready     (m_axis_tready),
        .m_axis_tdata      (m_axis_tdata),
        .m_axis_tlast      (m_axis_tlast),
        .m_axis_tuser      (m_axis_tuser),
        .mismatch_count    (mismatch_count),
        .bytes_outstanding (bytes_outstanding)
    );

    initial
    begin
        forever
        begin
            #2 clk = ~clk;
        end
    end

    // Receiver: random back-pressure, plus one long hold-off on request so that
    // the request queue fills and the input side has to stall.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_off_request)
            begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                hold_off_request = 1'b0;
            end
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial
    begin
        int quiet_cycles;
        quiet_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("FAIL backslash_unescape_decoder_top");
                $finish;
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= last;
        @(posedge clk);
        while (!s_axis_tready)
        begin
            @(posedge clk);
        end
    endtask

    task automatic send_escape(input logic [7:0] marker);
        send_byte(bud_pkg::CHAR_BACKSLASH, 1'b0);
        send_byte(marker, 1'b0);
    endtask

    function automatic logic [7:0] random_hex_char();
        int v;
        v = $urandom_range(15);
        if (v < 10)
        begin
            return 8'("0" + v);
        end
        if ($urandom_range(1) == 1)
        begin
            return 8'("a" + v - 10);
        end
        return 8'("A" + v - 10);
    endfunction

    // Half well-formed escapes with random content, the rest plain bytes,
    // unknown escapes and escapes broken at each stage.
    task automatic send_random_texts(input int n_items);
        int         sent;
        logic [7:0] chunk[$];
        sent = 0;
        while (sent < n_items)
        begin
            chunk.delete();
            case ($urandom_range(9))
                0, 1:
                begin
                    chunk.push_back(8'($urandom_range(255)));
                end
                2, 3:
                begin
                    chunk.push_back(bud_pkg::CHAR_BACKSLASH);
                    case ($urandom_range(3))
                        0: chunk.push_back(bud_pkg::CHAR_BACKSLASH);
                        1: chunk.push_back(bud_pkg::CHAR_T);
                        2: chunk.push_back(bud_pkg::CHAR_N);
                        default: chunk.push_back(bud_pkg::CHAR_R);
                    endcase
                end
                4, 5, 6:
                begin
                    chunk.push_back(bud_pkg::CHAR_BACKSLASH);
                    chunk.push_back(bud_pkg::CHAR_X);
                    chunk.push_back(random_hex_char());
                    chunk.push_back(random_hex_char());
                end
                7:
                begin
                    chunk.push_back(bud_pkg::CHAR_BACKSLASH);
                    chunk.push_back(8'($urandom_range(255)));
                end
                8:
                begin
                    chunk.push_back(bud_pkg::CHAR_BACKSLASH);
                    chunk.push_back(bud_pkg::CHAR_X);
                    chunk.push_back(8'($urandom_range(255)));
                end
                default:
                begin
                    chunk.push_back(bud_pkg::CHAR_BACKSLASH);
                    chunk.push_back(bud_pkg::CHAR_X);
                    chunk.push_back(random_hex_char());
                    chunk.push_back(8'($urandom_range(255)));
                end
            endcase
            foreach (chunk[i])
            begin
                send_byte(chunk[i], ($urandom_range(9) == 0));
                sent++;
            end
        end
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 32;
        recv_idle_pct = 75;

        send_byte(8'h00, 1'b1);
        send_escape(bud_pkg::CHAR_BACKSLASH);
        send_escape(bud_pkg::CHAR_T);
        send_escape(bud_pkg::CHAR_N);
        send_escape(bud_pkg::CHAR_R);
        send_escape(bud_pkg::CHAR_X);
        send_byte("a", 1'b0);
        send_byte("F", 1'b0);
        // A backslash breaks a half-read hex escape and opens a new one,
        // which the upper-case T then breaks in turn.
        send_escape(bud_pkg::CHAR_X);
        send_byte("7", 1'b0);
        send_byte(bud_pkg::CHAR_BACKSLASH, 1'b0);
        send_byte("T", 1'b0);
        send_escape(bud_pkg::CHAR_X);
        send_byte(8'hFF, 1'b0);
        send_byte(bud_pkg::CHAR_BACKSLASH, 1'b1);
        send_escape(bud_pkg::CHAR_X);
        send_byte("3", 1'b1);

        send_random_texts(ITEMS_PER_PHASE);

        send_idle_pct = 75;
        recv_idle_pct = 32;
        send_random_texts(ITEMS_PER_PHASE);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_off_request = 1'b1;
        send_random_texts(ITEMS_PER_PHASE);

        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (bytes_outstanding != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && bytes_outstanding == 0)
        begin
            $display("PASS backslash_unescape_decoder_top");
        end
        else
        begin
            $display("FAIL backslash_unescape_decoder_top");
        end
        $finish;
    end

endmodule

// ----- backslash_unescape_decoder_top.f -----
+incdir+design
design/bud_pkg.sv
design/bud_front.sv
design/bud_queue.sv
design/bud_back.sv
design/backslash_unescape_decoder_top.sv
tb/bud_decode_monitor.sv
tb/tb_backslash_unescape_decoder_top.sv
